// ===== sv/ssrfb_pkg.sv =====
package ssrfb_pkg;

   // Request commands; code 3 gives an all-blank frame
   typedef enum logic [1:0] {
      CMD_ROOM   = 2'd0,
      CMD_WATER  = 2'd1,
      CMD_SINGLE = 2'd2
   } cmd_type;

   // Segment byte, bit 7 is the decimal point
   typedef logic [7:0] seg_type;

   // Eight digit bytes, element 0 is digit 1 (rightmost)
   typedef seg_type [7:0] digit_buf_type;

   // Configuration register contents handed to the frame sequencer
   typedef struct packed {
      logic [3:0] brightness;
      logic [7:0] decode_select;
   } csr_type;

   // Configuration register indexes
   localparam logic CSR_BRIGHTNESS    = 1'b0;
   localparam logic CSR_DECODE_SELECT = 1'b1;

   localparam logic [3:0] DEFAULT_BRIGHT = 4'd8;
   localparam logic [9:0] READING_MAX    = 10'd999;
   localparam logic [9:0] TWO_DIGIT_MAX  = 10'd99;

   localparam seg_type SEG_POINT = 8'h80;
   localparam seg_type SEG_C     = 8'h0D;
   localparam seg_type SEG_H     = 8'h37;
   localparam seg_type SEG_DASH  = 8'h01;
   localparam seg_type SEG_BLANK = 8'h00;

   // Frame word positions
   localparam logic [3:0] WORD_NOOP     = 4'd0;
   localparam logic [3:0] WORD_DIGIT1   = 4'd1;
   localparam logic [3:0] WORD_DIGIT8   = 4'd8;
   localparam logic [3:0] WORD_DECODE   = 4'd9;
   localparam logic [3:0] WORD_INTEN    = 4'd10;
   localparam logic [3:0] WORD_SCAN     = 4'd11;
   localparam logic [3:0] WORD_SHUTDOWN = 4'd12;
   localparam logic [3:0] WORD_TEST     = 4'd13;

   // Driver register addresses
   localparam logic [3:0] ADDR_NOOP     = 4'h0;
   localparam logic [3:0] ADDR_DECODE   = 4'h9;
   localparam logic [3:0] ADDR_INTEN    = 4'hA;
   localparam logic [3:0] ADDR_SCAN     = 4'hB;
   localparam logic [3:0] ADDR_SHUTDOWN = 4'hC;
   localparam logic [3:0] ADDR_TEST     = 4'hF;

   localparam logic [7:0] SCAN_ALL_DIGITS = 8'h07;
   localparam logic [7:0] SHUTDOWN_NORMAL = 8'h01;
   localparam logic [7:0] TEST_OFF        = 8'h00;

   // Segment pattern of one decimal digit; anything above 9 is blank
   function automatic seg_type seg_of(input logic [3:0] d);
      seg_type s;
      unique case (d)
         4'd0:    s = 8'h7e;
         4'd1:    s = 8'h30;
         4'd2:    s = 8'h6d;
         4'd3:    s = 8'h79;
         4'd4:    s = 8'h33;
         4'd5:    s = 8'h5b;
         4'd6:    s = 8'h5f;
         4'd7:    s = 8'h70;
         4'd8:    s = 8'h7f;
         4'd9:    s = 8'h7b;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   // Hundreds of a value up to 999: multiply by 41/4096
   function automatic logic [3:0] hundreds_of(input logic [9:0] v);
      logic [15:0] p;
      p = {6'd0, v} * 16'd41;
      return p[15:12];
   endfunction

   // Tens of a value up to 99: multiply by 205/2048
   function automatic logic [3:0] tens_of(input logic [6:0] r);
      logic [15:0] p;
      p = {9'd0, r} * 16'd205;
      return p[14:11];
   endfunction

endpackage

// ===== sv/seven_segment_reading_frame_builder.sv =====
// Path: an accepted item passes the front stage register, the queue, the sequencer's frame index
// and the output register, and the fourteen words of a frame follow on consecutive cycles with no gaps.
// Throughput: the frame sequencer emits one word a cycle, fourteen words per item;
// up to QUEUE_DEPTH items are taken ahead of the sequencer, then busy rises.
// Results cannot be stalled; rsp_valid marks each word for exactly one cycle.
// Reset (synchronous): frame logic empties, brightness returns to 8, decode select to 0.
module seven_segment_reading_frame_builder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_cmd,
   input  logic [9:0] req_temp_tenths,
   input  logic [9:0] req_hum_tenths,
   input  logic [3:0] req_single_digit,
   output logic       rsp_valid,
   output logic [3:0] rsp_reg_addr,
   output logic [7:0] rsp_reg_data,
   output logic       rsp_last_word,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);
   import ssrfb_pkg::*;

   localparam int CREDIT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CREDIT_W-1:0] CREDIT_MAX = CREDIT_W'(QUEUE_DEPTH);

   logic                accept;
   logic                push, pop, q_empty;
   digit_buf_type       push_digits, q_head;
   logic [CREDIT_W-1:0] credit_ff, credit_in;
   logic [3:0]          brightness_ff, brightness_in;
   logic [7:0]          decode_ff,     decode_in;
   csr_type             csr;

   assign accept = start && !busy;
   assign busy   = credit_ff == CREDIT_MAX;

   // Count items accepted but not yet taken by the sequencer
   always_comb begin
      credit_in = credit_ff;
      if (accept && !pop) begin
         credit_in = credit_ff + 1'b1;
      end else if (pop && !accept) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   // Write configuration registers
   always_comb begin
      brightness_in = brightness_ff;
      decode_in     = decode_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BRIGHTNESS:    brightness_in = csr_write_data[3:0];
            CSR_DECODE_SELECT: decode_in     = csr_write_data;
            default:           decode_in     = decode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff     <= '0;
         brightness_ff <= DEFAULT_BRIGHT;
         decode_ff     <= 8'h00;
      end else begin
         credit_ff     <= credit_in;
         brightness_ff <= brightness_in;
         decode_ff     <= decode_in;
      end
   end

   assign csr.brightness    = brightness_ff;
   assign csr.decode_select = decode_ff;

   ssrfb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (req_cmd),
      .temp_tenths  (req_temp_tenths),
      .hum_tenths   (req_hum_tenths),
      .single_digit (req_single_digit),
      .push         (push),
      .push_digits  (push_digits)
   );

   ssrfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_digits (push_digits),
      .pop         (pop),
      .empty       (q_empty),
      .head_digits (q_head)
   );

   ssrfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_reg_addr  (rsp_reg_addr),
      .rsp_reg_data  (rsp_reg_data),
      .rsp_last_word (rsp_last_word)
   );

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CREDIT_MAX)
      else $error("more items in flight than queue slots");

endmodule

// ===== sv/ssrfb_front.sv =====
module ssrfb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [1:0]               cmd,
   input  logic [9:0]               temp_tenths,
   input  logic [9:0]               hum_tenths,
   input  logic [3:0]               single_digit,
   output logic                     push,
   output ssrfb_pkg::digit_buf_type push_digits
);
   import ssrfb_pkg::*;

   logic       s1_valid_ff;
   cmd_type    s1_cmd_ff,   s1_cmd_in;
   logic [3:0] s1_sd_ff;
   logic       s1_t_big_ff, s1_t_big_in;
   logic       s1_h_big_ff, s1_h_big_in;
   logic [3:0] s1_t_hun_ff, s1_t_hun_in;
   logic [3:0] s1_h_hun_ff, s1_h_hun_in;
   logic [6:0] s1_t_rem_ff, s1_t_rem_in;
   logic [6:0] s1_h_rem_ff, s1_h_rem_in;

   logic [9:0]    t_sat, h_sat;
   logic [15:0]   t_rem_wide, h_rem_wide;
   logic [3:0]    t_ten, t_unit, h_ten, h_unit;
   logic [15:0]   t_unit_wide, h_unit_wide;
   digit_buf_type digits;

   // Saturate readings and split off the hundreds
   always_comb begin
      t_sat       = (temp_tenths > READING_MAX) ? READING_MAX : temp_tenths;
      h_sat       = (hum_tenths > READING_MAX) ? READING_MAX : hum_tenths;
      s1_cmd_in   = cmd_type'(cmd);
      s1_t_big_in = t_sat > TWO_DIGIT_MAX;
      s1_h_big_in = h_sat > TWO_DIGIT_MAX;
      s1_t_hun_in = hundreds_of(t_sat);
      s1_h_hun_in = hundreds_of(h_sat);
      t_rem_wide  = {6'd0, t_sat} - {12'd0, s1_t_hun_in} * 16'd100;
      h_rem_wide  = {6'd0, h_sat} - {12'd0, s1_h_hun_in} * 16'd100;
      s1_t_rem_in = t_rem_wide[6:0];
      s1_h_rem_in = h_rem_wide[6:0];
   end

   // Hold the accepted item for the encode stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_cmd_ff   <= s1_cmd_in;
         s1_sd_ff    <= single_digit;
         s1_t_big_ff <= s1_t_big_in;
         s1_h_big_ff <= s1_h_big_in;
         s1_t_hun_ff <= s1_t_hun_in;
         s1_h_hun_ff <= s1_h_hun_in;
         s1_t_rem_ff <= s1_t_rem_in;
         s1_h_rem_ff <= s1_h_rem_in;
      end
   end

   // Split the remainders into tens and units
   always_comb begin
      t_ten       = tens_of(s1_t_rem_ff);
      h_ten       = tens_of(s1_h_rem_ff);
      t_unit_wide = {9'd0, s1_t_rem_ff} - {12'd0, t_ten} * 16'd10;
      h_unit_wide = {9'd0, s1_h_rem_ff} - {12'd0, h_ten} * 16'd10;
      t_unit      = t_unit_wide[3:0];
      h_unit      = h_unit_wide[3:0];
   end

   // Encode the eight digit bytes for the command
   always_comb begin
      digits = '{default: SEG_BLANK};
      case (s1_cmd_ff)
         CMD_ROOM: begin
            digits[7] = s1_t_big_ff ? seg_of(s1_t_hun_ff) : SEG_BLANK;
            digits[6] = seg_of(t_ten) | SEG_POINT;
            digits[5] = seg_of(t_unit);
            digits[4] = SEG_C;
            digits[2] = s1_h_big_ff ? seg_of(s1_h_hun_ff) : seg_of(h_ten);
            digits[1] = s1_h_big_ff ? seg_of(h_ten) : seg_of(h_unit);
            digits[0] = SEG_H;
         end
         CMD_WATER: begin
            digits[7] = SEG_DASH;
            digits[6] = SEG_DASH;
            digits[5] = seg_of(s1_t_hun_ff);
            digits[4] = seg_of(t_ten) | SEG_POINT;
            digits[3] = seg_of(t_unit);
            digits[2] = SEG_C;
            digits[1] = SEG_DASH;
            digits[0] = SEG_DASH;
         end
         CMD_SINGLE: begin
            digits[0] = seg_of(s1_sd_ff);
         end
         default: begin
            digits = '{default: SEG_BLANK};
         end
      endcase
   end

   assign push        = s1_valid_ff;
   assign push_digits = digits;

endmodule

// ===== sv/ssrfb_queue.sv =====
module ssrfb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ssrfb_pkg::digit_buf_type push_digits,
   input  logic                     pop,
   output logic                     empty,
   output ssrfb_pkg::digit_buf_type head_digits
);
   import ssrfb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   digit_buf_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             full;

   assign empty       = count_ff == '0;
   assign full        = count_ff == CNT_FULL;
   assign head_digits = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_digits;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

// ===== sv/ssrfb_back.sv =====
module ssrfb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ssrfb_pkg::csr_type       csr,
   input  logic                     q_empty,
   input  ssrfb_pkg::digit_buf_type q_head,
   output logic                     pop,
   output logic                     rsp_valid,
   output logic [3:0]               rsp_reg_addr,
   output logic [7:0]               rsp_reg_data,
   output logic                     rsp_last_word
);
   import ssrfb_pkg::*;

   logic          active_ff, active_in;
   logic [3:0]    idx_ff,    idx_in;
   digit_buf_type digits_ff, digits_in;

   logic          valid_ff;
   logic [3:0]    addr_ff,   addr_in;
   logic [7:0]    data_ff,   data_in;
   logic          last_ff,   last_in;
   logic [3:0]    digit_sel;
   logic [7:0]    intensity;

   // Take the next item when idle or on the final word of the current one
   assign pop = !q_empty && (!active_ff || idx_ff == WORD_TEST);

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      digits_in = digits_ff;
      if (pop) begin
         active_in = 1'b1;
         idx_in    = WORD_NOOP;
         digits_in = q_head;
      end else if (active_ff) begin
         if (idx_ff == WORD_TEST) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   // Build the word at the current frame position
   always_comb begin
      digit_sel = idx_ff - WORD_DIGIT1;
      intensity = {4'd0, (csr.brightness == 4'd0) ? DEFAULT_BRIGHT : csr.brightness};
      last_in   = 1'b0;
      unique case (idx_ff) inside
         WORD_NOOP: begin
            addr_in = ADDR_NOOP;
            data_in = 8'h00;
         end
         [WORD_DIGIT1:WORD_DIGIT8]: begin
            addr_in = idx_ff;
            data_in = digits_ff[digit_sel[2:0]];
         end
         WORD_DECODE: begin
            addr_in = ADDR_DECODE;
            data_in = csr.decode_select;
         end
         WORD_INTEN: begin
            addr_in = ADDR_INTEN;
            data_in = intensity;
         end
         WORD_SCAN: begin
            addr_in = ADDR_SCAN;
            data_in = SCAN_ALL_DIGITS;
         end
         WORD_SHUTDOWN: begin
            addr_in = ADDR_SHUTDOWN;
            data_in = SHUTDOWN_NORMAL;
         end
         WORD_TEST: begin
            addr_in = ADDR_TEST;
            data_in = TEST_OFF;
            last_in = 1'b1;
         end
         default: begin
            addr_in = ADDR_NOOP;
            data_in = 8'h00;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= WORD_NOOP;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         valid_ff  <= active_ff;
      end
      digits_ff <= digits_in;
      addr_ff   <= addr_in;
      data_ff   <= data_in;
      last_ff   <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_reg_addr  = addr_ff;
   assign rsp_reg_data  = data_ff;
   assign rsp_last_word = valid_ff && last_ff;

   a_last_is_test: assert property (@(posedge clock) disable iff (reset)
      rsp_last_word |-> (rsp_valid && rsp_reg_addr == ADDR_TEST))
      else $error("last word is not the display test register");

endmodule
